// File: src/qtf_pkg.sv
`default_nettype none

package qtf_pkg;

	// Default sizing
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;

	// Field and register widths
	localparam int SCALE_W   = 24;
	localparam int LIMIT_W   = 16;
	localparam int ALPHA_W   = 17;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int SPEED_W   = 16;
	localparam int WCOUNT_W  = 24;
	localparam int FILT_W    = 32;

	// Filter fixed point: Q16 weights, round half up
	localparam int                 FILT_SHIFT = 16;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
	localparam logic [FILT_SHIFT-1:0] ROUND_HALF = 16'h8000;

	// Register reset values
	localparam logic [SCALE_W-1:0] RPM_SCALE_RST    = 24'd246995;
	localparam logic [LIMIT_W-1:0] RPM_LIMIT_RST    = 16'd10000;
	localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 17'd6554;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 2'd2;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_ALIGN  = 2'd2,
		CMD_NONE   = 2'd3
	} qtf_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAW,
		ST_CLIP,
		ST_NEW,
		ST_OLD,
		ST_SUM,
		ST_OUT
	} qtf_state_t;

	// Quadrature transition decode: {previous phase, new phase} -> -1, 0, +1
	function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
		logic signed [1:0] s;
		unique case (idx) inside
			4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
			default:                  s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// File: src/quadrature_tachometer_filtered_unit.sv
`default_nettype none

// Quadrature tachometer with smoothed speed. Encoder samples (cmd 0) and
// phase-align items (cmd 2) are taken while idle and give no result; a sample
// steps a saturating signed window count by -1, 0 or +1. A sample-period tick
// (cmd 1) is worked through by a six-step sequencer: one shared multiplier is
// used three times in turn (|count| * rpm_scale, alpha * clipped speed,
// (1 - alpha) * old filter value), with a clip step after the first product
// and a sum step after the last. With the output free, the result is loaded
// into the output register as the sequencer returns to idle, and the next
// input transfer can follow once it is idle. The input is not ready while the
// sequencer is busy, and a tick waits in its last step while the output
// register still holds an untaken result. A result is produced only for a
// tick: the filtered speed's integer part, the raw window count
// (sign-extended or cut to 24 bits) and a clip flag. Configuration writes are
// single-cycle and should be made only while the block is idle.

module quadrature_tachometer_filtered_unit #(
	parameter int COUNT_WIDTH = qtf_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = qtf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_wr_en,
	input  wire logic [qtf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [qtf_pkg::CFG_W-1:0]       cfg_data,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      cmd,
	input  wire logic                            phase_a,
	input  wire logic                            phase_b,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [qtf_pkg::SPEED_W-1:0]          speed_rpm,
	output logic signed [qtf_pkg::WCOUNT_W-1:0]  window_count,
	output logic                                 speed_clipped
);
	import qtf_pkg::*;

	// Multiplier sizing: operand A carries |count|, the clipped speed
	// (limit << FRAC_BITS) or the 32-bit filter state.
	localparam int LW      = LIMIT_W + FRAC_BITS;
	localparam int OA1     = (COUNT_WIDTH > LW) ? COUNT_WIDTH : LW;
	localparam int OA      = (OA1 > FILT_W) ? OA1 : FILT_W;
	localparam int PROD_W  = OA + SCALE_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int WX      = (COUNT_WIDTH > WCOUNT_W) ? COUNT_WIDTH : WCOUNT_W;

	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	// Configuration
	logic [SCALE_W-1:0] rpm_scale_q;
	logic [LIMIT_W-1:0] rpm_limit_q;
	logic [ALPHA_W-1:0] filter_alpha_q;

	// Architectural state
	logic [1:0]                     phase_q;
	logic signed [COUNT_WIDTH-1:0]  cnt_q;
	logic [FILT_W-1:0]              filt_q;

	// Tick working registers
	qtf_state_t                     state_q, state_d;
	logic signed [COUNT_WIDTH-1:0]  snap_q;
	logic [COUNT_WIDTH-1:0]         mag_q;
	logic [PROD_W-1:0]              prod_q;
	logic [LW-1:0]                  raw_q;
	logic                           clip_q;
	logic [SUM_W-1:0]               acc_q;

	// Result register
	logic                           out_valid_q;
	logic [SPEED_W-1:0]             speed_q;
	logic signed [WCOUNT_W-1:0]     wcount_q;
	logic                           clipped_q;

	logic                           in_fire;
	logic                           out_load;
	logic [1:0]                     phase_new;
	logic signed [1:0]              step;
	logic signed [COUNT_WIDTH-1:0]  cnt_step;
	logic [COUNT_WIDTH-1:0]         cnt_neg;
	logic [ALPHA_W-1:0]             alpha_sat;
	logic [OA-1:0]                  mul_a;
	logic [SCALE_W-1:0]             mul_b;
	logic [PROD_W-1:0]              mul_p;
	logic [PROD_W-1:0]              lim;
	logic [SUM_W-1:0]               sum;
	logic [SUM_W-1:0]               sum_shr;
	logic [FILT_W-1:0]              filt_next;
	logic [FILT_W-1:0]              filt_shr;
	logic [SPEED_W-1:0]             speed_sat;
	logic signed [WX-1:0]           snap_ext;

	assign in_fire   = in_valid && in_ready;
	assign phase_new = {phase_a, phase_b};

	// Count step with saturation at either end
	assign step     = quad_step({phase_q, phase_new});
	always_comb begin
		if ((step == 2'sd1) && (cnt_q == CNT_MAX)) begin
			cnt_step = cnt_q;
		end else if ((step == -2'sd1) && (cnt_q == CNT_MIN)) begin
			cnt_step = cnt_q;
		end else begin
			cnt_step = cnt_q + COUNT_WIDTH'(step);
		end
	end

	// Magnitude; the most negative count gives 2^(COUNT_WIDTH-1) unsigned
	assign cnt_neg   = ~cnt_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
	assign alpha_sat = (filter_alpha_q > ALPHA_ONE) ? ALPHA_ONE : filter_alpha_q;
	assign lim       = PROD_W'({rpm_limit_q, {FRAC_BITS{1'b0}}});

	// Shared multiplier, operands steered by the sequencer
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RAW: begin
				mul_a = OA'(mag_q);
				mul_b = rpm_scale_q;
			end
			ST_NEW: begin
				mul_a = OA'(raw_q);
				mul_b = SCALE_W'(alpha_sat);
			end
			ST_OLD: begin
				mul_a = OA'(filt_q);
				mul_b = SCALE_W'(ALPHA_ONE - alpha_sat);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Filter sum, >> 16 and saturate to 32 bits
	assign sum       = acc_q + SUM_W'(prod_q);
	assign sum_shr   = sum >> FILT_SHIFT;
	assign filt_next = (|sum_shr[SUM_W-1:FILT_W]) ? '1 : sum_shr[FILT_W-1:0];

	// Integer part of the filter state, already updated once in the sum step
	assign filt_shr  = filt_q >> FRAC_BITS;
	assign speed_sat = (|filt_shr[FILT_W-1:SPEED_W]) ? '1 : filt_shr[SPEED_W-1:0];

	assign snap_ext  = WX'(snap_q);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (qtf_cmd_t'(cmd) == CMD_TICK)) begin
					state_d = ST_RAW;
				end
			end
			ST_RAW:  state_d = ST_CLIP;
			ST_CLIP: state_d = ST_NEW;
			ST_NEW:  state_d = ST_OLD;
			ST_OLD:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_OUT;
			ST_OUT: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration, architectural state, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_scale_q    <= RPM_SCALE_RST;
			rpm_limit_q    <= RPM_LIMIT_RST;
			filter_alpha_q <= FILTER_ALPHA_RST;
			phase_q        <= '0;
			cnt_q          <= '0;
			filt_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_RPM_SCALE) begin
					rpm_scale_q <= cfg_data[SCALE_W-1:0];
				end else if (cfg_index == REG_RPM_LIMIT) begin
					rpm_limit_q <= cfg_data[LIMIT_W-1:0];
				end else if (cfg_index == REG_FILTER_ALPHA) begin
					filter_alpha_q <= cfg_data[ALPHA_W-1:0];
				end
			end

			if (in_fire) begin
				unique case (qtf_cmd_t'(cmd))
					CMD_SAMPLE: begin
						cnt_q   <= cnt_step;
						phase_q <= phase_new;
					end
					CMD_TICK:  cnt_q   <= '0;
					CMD_ALIGN: phase_q <= phase_new;
					CMD_NONE:  ;
					default:   ;
				endcase
			end

			if (state_q == ST_SUM) begin
				filt_q <= filt_next;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Tick datapath and result payload
	always_ff @(posedge clk) begin
		if (in_fire && (qtf_cmd_t'(cmd) == CMD_TICK)) begin
			snap_q <= cnt_q;
			mag_q  <= cnt_q[COUNT_WIDTH-1] ? cnt_neg : cnt_q;
		end
		case (state_q)
			ST_RAW: prod_q <= mul_p;
			ST_CLIP: begin
				if (prod_q > lim) begin
					raw_q  <= lim[LW-1:0];
					clip_q <= 1'b1;
				end else begin
					raw_q  <= prod_q[LW-1:0];
					clip_q <= 1'b0;
				end
			end
			ST_NEW: prod_q <= mul_p;
			ST_OLD: begin
				acc_q  <= SUM_W'(prod_q) + SUM_W'(ROUND_HALF);
				prod_q <= mul_p;
			end
			default: ;
		endcase
		if (out_load) begin
			speed_q   <= speed_sat;
			wcount_q  <= snap_ext[WCOUNT_W-1:0];
			clipped_q <= clip_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign speed_rpm     = speed_q;
	assign window_count  = wcount_q;
	assign speed_clipped = clipped_q;

endmodule

`default_nettype wire

// File: src/qtf_checker.sv
`default_nettype none

module qtf_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic [1:0]                      cmd,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [qtf_pkg::SPEED_W-1:0]     speed_rpm,
	input wire logic [qtf_pkg::WCOUNT_W-1:0]    window_count,
	input wire logic                            speed_clipped
);
	import qtf_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed_rpm)
			&& $stable(window_count) && $stable(speed_clipped))
		else $error("result changed while stalled");

	// a tick transfer makes the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_TICK) |=> !in_ready)
		else $error("input ready right after tick");

	// sample, align and unused commands give no result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd != CMD_TICK) && !out_valid |=> !out_valid)
		else $error("result without tick");

	// a new result appears only from the busy sequence
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while idle");

endmodule

bind quadrature_tachometer_filtered_unit qtf_checker u_qtf_checker (.*);

`default_nettype wire
